FILE: rtl/core/tcm_pkg.sv
// ----------------------------------------------------------------------------
// tcm_pkg
// Shared types, widths and reset values of the transaction contention manager.
// ----------------------------------------------------------------------------
package tcm_pkg;

   localparam int CMD_W       = 2;
   localparam int TID_W       = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int THRESH_W    = 16;
   localparam int INIT_BO_W   = 16;
   localparam int STEPS_W     = 5;
   localparam int WCOUNT_W    = 16;
   localparam int BACKOFF_W   = 32;

   localparam int DEF_THREADS     = 16;
   localparam int DEF_STAMP_WIDTH = 32;

   localparam logic [THRESH_W-1:0]  THRESH_RESET  = 16'd4;
   localparam logic [INIT_BO_W-1:0] INIT_BO_RESET = 16'd64;
   localparam logic [STEPS_W-1:0]   STEPS_RESET   = 5'd10;
   // table backoff after reset follows the reset value of initial_backoff
   localparam logic [BACKOFF_W-1:0] BACKOFF_RESET = BACKOFF_W'(INIT_BO_RESET);

   typedef enum logic [CMD_W-1:0] {
      CMD_START    = 2'd0,
      CMD_WRITE    = 2'd1,
      CMD_CONFLICT = 2'd2,
      CMD_ROLLBACK = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROMOTE_THRESHOLD = 2'd0,
      CSR_INITIAL_BACKOFF   = 2'd1,
      CSR_MAX_BACKOFF_STEPS = 2'd2
   } csr_index_type;

endpackage

FILE: rtl/core/tcm_req_if.sv
// ----------------------------------------------------------------------------
// tcm_req_if
// Request channel: one contention-manager command per item.
// ----------------------------------------------------------------------------
interface tcm_req_if;
   import tcm_pkg::*;

   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [TID_W-1:0] thread_id;
   logic [TID_W-1:0] holder_id;
   logic             restarted;

   modport source (output valid, output command, output thread_id, output holder_id,
                   output restarted, input ready);
   modport sink   (input valid, input command, input thread_id, input holder_id,
                   input restarted, output ready);
endinterface

FILE: rtl/core/tcm_rsp_if.sv
// ----------------------------------------------------------------------------
// tcm_rsp_if
// Response channel: decision and backoff bound, one item per request.
// ----------------------------------------------------------------------------
interface tcm_rsp_if;
   import tcm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 decision;
   logic [BACKOFF_W-1:0] backoff_limit;

   modport source (output valid, output decision, output backoff_limit, input ready);
   modport sink   (input valid, input decision, input backoff_limit, output ready);
endinterface

FILE: rtl/core/tcm_ram.sv
// ----------------------------------------------------------------------------
// tcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/txn_contention_manager_top.sv
// ----------------------------------------------------------------------------
// txn_contention_manager_top
// Per-thread transaction contention manager: start, write, conflict check
// and rollback commands against a per-thread table held in RAM.
// ----------------------------------------------------------------------------
// usage:
//  - req_chan carries one command per item (valid/ready), rsp_chan returns
//    exactly one item per request, in order.
//  - csr_wr_en/csr_index/csr_wr_data write the threshold, initial backoff and
//    step limit; write them only while no request is in flight.
//  - an accepted request is held in the lookup stage, and its result is
//    registered in the output register that drives rsp_chan.
//  - throughput: one item per cycle when not stalled; two mirrored table RAMs
//    let a conflict check read requester and owner entries in the same cycle,
//    and a write-back to the entry read at the same edge is forwarded.
//  - reset clears every table entry at once through per-entry valid bits;
//    there is no clearing sweep, so requests are taken the cycle after reset.
//  - when rsp_chan stalls, the result waits in the output register, one more
//    request waits in the lookup stage, and req_chan.ready then drops.
// ----------------------------------------------------------------------------
module txn_contention_manager_top #(
   parameter int THREADS     = tcm_pkg::DEF_THREADS,
   parameter int STAMP_WIDTH = tcm_pkg::DEF_STAMP_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   tcm_req_if.sink                        req_chan,
   tcm_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [tcm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcm_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import tcm_pkg::*;

   localparam int IDX_W = $clog2(THREADS);
   localparam int MOD_W = 9;
   localparam logic [STAMP_WIDTH-1:0] STAMP_ONES = '1;
   localparam logic [STAMP_WIDTH-1:0] STAMP_TOP  = STAMP_ONES - 1'b1;

   typedef struct packed {
      logic [STAMP_WIDTH-1:0] stamp;
      logic                   aborted;
      logic [WCOUNT_W-1:0]    wcount;
      logic [STEPS_W-1:0]     steps;
      logic [BACKOFF_W-1:0]   backoff;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);
   localparam entry_type RESET_ENT = '{stamp: '0, aborted: 1'b0, wcount: '0,
                                       steps: '0, backoff: BACKOFF_RESET};

   // thread index wraps modulo THREADS
   function automatic logic [IDX_W-1:0] tid_wrap(input logic [TID_W-1:0] v);
      logic [MOD_W-1:0] r;
      r = MOD_W'(v);
      for (int i = 0; i < 8; i++) begin
         if (r >= MOD_W'(THREADS)) begin
            r = r - MOD_W'(THREADS);
         end
      end
      return r[IDX_W-1:0];
   endfunction

   // configuration
   logic [THRESH_W-1:0]  thresh_ff,  thresh_in;
   logic [INIT_BO_W-1:0] init_bo_ff, init_bo_in;
   logic [STEPS_W-1:0]   max_st_ff,  max_st_in;

   // lookup stage
   logic                   s1_valid_ff, s1_valid_in;
   cmd_type                s1_cmd_ff;
   logic [IDX_W-1:0]       s1_me_ff, s1_own_ff;
   logic                   s1_restart_ff;
   logic                   fwd_a_ff, fwd_b_ff, vld_a_ff, vld_b_ff;
   entry_type              fwd_ent_ff;
   logic [THREADS-1:0]     valid_ff, valid_in;
   logic [STAMP_WIDTH-1:0] glob_ff, glob_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_dec_ff;
   logic [BACKOFF_W-1:0]   rsp_limit_ff;

   logic                   accept, advance;
   logic [IDX_W-1:0]       req_me, req_own;
   logic [ENTRY_W-1:0]     ram_a_rd, ram_b_rd;
   entry_type              ent_a, ent_b, ent_new;
   logic                   wr_req, wr_en;
   logic [IDX_W-1:0]       wr_idx;
   logic                   decision;
   logic [BACKOFF_W-1:0]   limit;

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign req_me         = tid_wrap(req_chan.thread_id);
   assign req_own        = tid_wrap(req_chan.holder_id);
   assign wr_en          = advance && wr_req;

   tcm_ram #(.WIDTH(ENTRY_W), .DEPTH(THREADS)) u_ram_self (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (ent_new),
      .rd_en   (accept),
      .rd_addr (req_me),
      .rd_data (ram_a_rd)
   );

   tcm_ram #(.WIDTH(ENTRY_W), .DEPTH(THREADS)) u_ram_owner (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (ent_new),
      .rd_en   (accept),
      .rd_addr (req_own),
      .rd_data (ram_b_rd)
   );

   // forwarded write-back wins, then untouched entries read as reset
   always_comb begin
      ent_a = fwd_a_ff ? fwd_ent_ff : (vld_a_ff ? entry_type'(ram_a_rd) : RESET_ENT);
      ent_b = fwd_b_ff ? fwd_ent_ff : (vld_b_ff ? entry_type'(ram_b_rd) : RESET_ENT);
   end

   always_comb begin
      ent_new  = ent_a;
      wr_idx   = s1_me_ff;
      wr_req   = 1'b0;
      decision = 1'b0;
      limit    = '0;
      glob_in  = glob_ff;
      case (s1_cmd_ff)
         CMD_START: begin
            ent_new.stamp   = STAMP_ONES;
            ent_new.aborted = 1'b0;
            ent_new.wcount  = '0;
            if (!s1_restart_ff) begin
               ent_new.steps   = '0;
               ent_new.backoff = BACKOFF_W'(init_bo_ff);
            end
            wr_req = 1'b1;
         end
         CMD_WRITE: begin
            if (!ent_a.aborted) begin
               decision = 1'b1;
               wr_req   = 1'b1;
               if (ent_a.wcount != '1) begin
                  ent_new.wcount = ent_a.wcount + 1'b1;
               end
               if (ent_a.stamp == STAMP_ONES && ent_new.wcount == thresh_ff) begin
                  ent_new.stamp = glob_ff;
                  if (glob_ff < STAMP_TOP) begin
                     glob_in = glob_ff + 1'b1;
                  end
               end
            end
         end
         CMD_CONFLICT: begin
            if (ent_a.aborted || ent_a.stamp == STAMP_ONES) begin
               decision = 1'b1;
            end else if (ent_b.stamp < ent_a.stamp) begin
               decision = !ent_b.aborted;
            end else begin
               // older or equal requester wins, owner gets aborted
               ent_new         = ent_b;
               ent_new.aborted = 1'b1;
               wr_idx          = s1_own_ff;
               wr_req          = 1'b1;
            end
         end
         CMD_ROLLBACK: begin
            if (ent_a.steps < max_st_ff) begin
               ent_new.steps   = ent_a.steps + 1'b1;
               ent_new.backoff = ent_a.backoff[BACKOFF_W-1] ? '1 : (ent_a.backoff << 1);
               wr_req          = 1'b1;
            end
            limit = ent_new.backoff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      thresh_in  = thresh_ff;
      init_bo_in = init_bo_ff;
      max_st_in  = max_st_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_PROMOTE_THRESHOLD: thresh_in  = THRESH_W'(csr_wr_data);
            CSR_INITIAL_BACKOFF:   init_bo_in = INIT_BO_W'(csr_wr_data);
            CSR_MAX_BACKOFF_STEPS: max_st_in  = csr_wr_data[STEPS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);
      valid_in     = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= THRESH_RESET;
         init_bo_ff   <= INIT_BO_RESET;
         max_st_ff    <= STEPS_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         glob_ff      <= '0;
      end else begin
         thresh_ff    <= thresh_in;
         init_bo_ff   <= init_bo_in;
         max_st_ff    <= max_st_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         if (advance) begin
            glob_ff <= glob_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff     <= cmd_type'(req_chan.command);
         s1_me_ff      <= req_me;
         s1_own_ff     <= req_own;
         s1_restart_ff <= req_chan.restarted;
         vld_a_ff      <= valid_ff[req_me];
         vld_b_ff      <= valid_ff[req_own];
         // write-back at this edge is not yet visible in the ram read
         fwd_a_ff      <= wr_en && (wr_idx == req_me);
         fwd_b_ff      <= wr_en && (wr_idx == req_own);
         fwd_ent_ff    <= ent_new;
      end
      if (advance) begin
         rsp_dec_ff   <= decision;
         rsp_limit_ff <= limit;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.decision      = rsp_dec_ff;
   assign rsp_chan.backoff_limit = rsp_limit_ff;

`ifndef SYNTHESIS
   a_glob_below_ones: assert property (@(posedge clock) disable iff (reset)
      glob_ff != STAMP_ONES)
      else $error("global stamp reached the timid value");

   a_glob_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> glob_ff >= $past(glob_ff))
      else $error("global stamp went backwards");

   a_write_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready)))
      else $error("table written without a result slot");

   a_limit_zero_non_rollback: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_cmd_ff != CMD_ROLLBACK) |=> rsp_chan.backoff_limit == '0)
      else $error("nonzero backoff limit on a non-rollback item");
`endif
endmodule

FILE: verif/tb_txn_contention_manager.sv
// ----------------------------------------------------------------------------
// tb_txn_contention_manager
// Self-checking bench for the contention manager: a driver feeds command
// items from a backlog, a scoreboard model of the per-thread table predicts
// each response, and a monitor compares responses in order across several
// register settings, with random request gaps and long response stalls.
// ----------------------------------------------------------------------------
module testbench;
   import tcm_pkg::*;

   localparam int THREAD_CNT = DEF_THREADS;
   localparam logic [DEF_STAMP_WIDTH-1:0] TIMID_STAMP = '1;
   localparam int LONG_HOLD = 80;

   typedef struct packed {
      cmd_type          command;
      logic [TID_W-1:0] thread_id;
      logic [TID_W-1:0] holder_id;
      logic             restarted;
   } cmd_item_type;

   typedef struct packed {
      logic                 decision;
      logic [BACKOFF_W-1:0] backoff_limit;
   } verdict_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   tcm_req_if req_if ();
   tcm_rsp_if rsp_if ();

   txn_contention_manager_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // register copies used by the scoreboard model
   logic [THRESH_W-1:0]  thresh_cfg  = THRESH_RESET;
   logic [INIT_BO_W-1:0] init_bo_cfg = INIT_BO_RESET;
   logic [STEPS_W-1:0]   steps_cfg   = STEPS_RESET;

   // scoreboard model of the thread table
   logic [DEF_STAMP_WIDTH-1:0] stamp_of     [THREAD_CNT];
   logic                       aborted_of   [THREAD_CNT];
   logic [WCOUNT_W-1:0]        writes_of    [THREAD_CNT];
   logic [STEPS_W-1:0]         rollbacks_of [THREAD_CNT];
   logic [BACKOFF_W-1:0]       bound_of     [THREAD_CNT];
   logic [DEF_STAMP_WIDTH-1:0] stamp_counter;

   cmd_item_type cmd_backlog [$];
   verdict_type  verdict_q [$];
   cmd_item_type on_wire;
   verdict_type  want;
   bit           idle_on = 1'b1;
   int           send_gap;
   int           stall_left;
   int           hold_left;
   int           hold_requests = 0;
   int           holds_done;
   int unsigned  queued_total = 0;
   int unsigned  items_sent = 0;
   int unsigned  results_checked = 0;
   int unsigned  errors = 0;

   function automatic verdict_type predict_verdict(input cmd_item_type it);
      verdict_type      v;
      logic [TID_W-1:0] me;
      logic [TID_W-1:0] own;
      v.decision = 1'b0;
      v.backoff_limit = '0;
      me = it.thread_id;
      own = it.holder_id;
      case (it.command)
         CMD_START: begin
            stamp_of[me] = TIMID_STAMP;
            aborted_of[me] = 1'b0;
            writes_of[me] = '0;
            if (!it.restarted) begin
               rollbacks_of[me] = '0;
               bound_of[me] = BACKOFF_W'(init_bo_cfg);
            end
         end
         CMD_WRITE: begin
            if (!aborted_of[me]) begin
               v.decision = 1'b1;
               if (writes_of[me] != '1) writes_of[me] = writes_of[me] + 1'b1;
               // a threshold of zero never matches since the count is at least one here
               if (stamp_of[me] == TIMID_STAMP && writes_of[me] == thresh_cfg) begin
                  stamp_of[me] = stamp_counter;
                  if (stamp_counter < TIMID_STAMP - 1) stamp_counter = stamp_counter + 1'b1;
               end
            end
         end
         CMD_CONFLICT: begin
            if (aborted_of[me] || stamp_of[me] == TIMID_STAMP) begin
               v.decision = 1'b1;
            end else if (stamp_of[own] < stamp_of[me]) begin
               v.decision = !aborted_of[own];
            end else begin
               aborted_of[own] = 1'b1;
            end
         end
         CMD_ROLLBACK: begin
            if (rollbacks_of[me] < steps_cfg) begin
               rollbacks_of[me] = rollbacks_of[me] + 1'b1;
               bound_of[me] = bound_of[me][BACKOFF_W-1] ? '1 : bound_of[me] << 1;
            end
            v.backoff_limit = bound_of[me];
         end
         default: begin
         end
      endcase
      return v;
   endfunction

   function automatic int idle_span();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int pick_thread();
      // keep most traffic on a few threads so conflicts hit live transactions
      if ($urandom_range(0, 99) < 70) return $urandom_range(0, 3);
      return $urandom_range(0, THREAD_CNT - 1);
   endfunction

   function automatic void push_cmd(cmd_type c, int t, int o, int r);
      cmd_item_type it;
      it.command = c;
      it.thread_id = t[TID_W-1:0];
      it.holder_id = o[TID_W-1:0];
      it.restarted = r[0];
      cmd_backlog.push_back(it);
      queued_total++;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
         for (int t = 0; t < THREAD_CNT; t++) begin
            stamp_of[t] = '0;
            aborted_of[t] = 1'b0;
            writes_of[t] = '0;
            rollbacks_of[t] = '0;
            bound_of[t] = BACKOFF_RESET;
         end
         stamp_counter = '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            verdict_q.push_back(predict_verdict(on_wire));
            items_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
               on_wire = cmd_backlog.pop_front();
               req_if.valid <= 1'b1;
               req_if.command <= on_wire.command;
               req_if.thread_id <= on_wire.thread_id;
               req_if.holder_id <= on_wire.holder_id;
               req_if.restarted <= on_wire.restarted;
               send_gap = idle_on ? idle_span() : 0;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor and response checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
         hold_left = 0;
         holds_done = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_checked++;
            if (verdict_q.size() == 0) begin
               $error("unexpected item: decision %0d, backoff_limit %0d",
                      rsp_if.decision, rsp_if.backoff_limit);
               errors++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_if.decision !== want.decision) begin
                  $error("decision mismatch: expected %0d, actual %0d",
                         want.decision, rsp_if.decision);
                  errors++;
               end
               if (rsp_if.backoff_limit !== want.backoff_limit) begin
                  $error("backoff_limit mismatch: expected %0d, actual %0d",
                         want.backoff_limit, rsp_if.backoff_limit);
                  errors++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (holds_done != hold_requests) begin
            // long back-pressure while the driver keeps offering items
            holds_done++;
            hold_left = LONG_HOLD - 1;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            stall_left = idle_on ? idle_span() : 0;
            if (stall_left > 0) begin
               stall_left--;
               rsp_if.ready <= 1'b0;
            end else begin
               rsp_if.ready <= 1'b1;
            end
         end
      end
   end

   // sampled mid-cycle so the driver's updates of the same edge are settled
   task automatic wait_drained();
      while (cmd_backlog.size() != 0 || req_if.valid || verdict_q.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
   endtask

   task automatic configure(logic [THRESH_W-1:0] th, logic [INIT_BO_W-1:0] ib,
                            logic [STEPS_W-1:0] ms);
      write_csr(CSR_PROMOTE_THRESHOLD, th);
      write_csr(CSR_INITIAL_BACKOFF, ib);
      write_csr(CSR_MAX_BACKOFF_STEPS, CSR_DATA_W'(ms));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      thresh_cfg = th;
      init_bo_cfg = ib;
      steps_cfg = ms;
   endtask

   // transaction episodes with random content, plus some raw noise items
   task automatic fill_random(int unsigned count);
      int unsigned base;
      int          t;
      int          n;
      int          cap;
      base = queued_total;
      while (queued_total - base < count) begin
         if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 3))
               push_cmd(cmd_type'($urandom_range(0, 3)), $urandom_range(0, 15),
                        $urandom_range(0, 15), $urandom_range(0, 1));
         end else begin
            t = pick_thread();
            push_cmd(CMD_START, t, $urandom_range(0, 15), $urandom_range(0, 1));
            cap = (thresh_cfg == 0 || thresh_cfg > 8) ? 6 : thresh_cfg + 2;
            n = $urandom_range(0, cap);
            repeat (n) begin
               push_cmd(CMD_WRITE, t, $urandom_range(0, 15), $urandom_range(0, 1));
               if ($urandom_range(0, 99) < 40)
                  push_cmd(CMD_CONFLICT, t, pick_thread(), $urandom_range(0, 1));
            end
            if ($urandom_range(0, 99) < 35)
               push_cmd(CMD_ROLLBACK, t, $urandom_range(0, 15), $urandom_range(0, 1));
         end
      end
   endtask

   task automatic run_phase(logic [THRESH_W-1:0] th, logic [INIT_BO_W-1:0] ib,
                            logic [STEPS_W-1:0] ms, bit idle, bit hold);
      wait_drained();
      configure(th, ib, ms);
      idle_on = idle;
      fill_random(170);
      if (hold) hold_requests++;
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.command = CMD_START;
      req_if.thread_id = '0;
      req_if.holder_id = '0;
      req_if.restarted = 1'b0;
      rsp_if.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed items on the reset register values
      push_cmd(CMD_ROLLBACK, 0, 15, 1);
      push_cmd(CMD_CONFLICT, 1, 1, 0);     // self conflict on a never-started thread
      push_cmd(CMD_WRITE, 1, 0, 0);        // refused, thread aborted
      push_cmd(CMD_START, 1, 0, 0);
      repeat (4) push_cmd(CMD_WRITE, 1, 0, 0);
      push_cmd(CMD_START, 15, 15, 0);
      repeat (4) push_cmd(CMD_WRITE, 15, 0, 1);
      push_cmd(CMD_CONFLICT, 15, 1, 0);    // older owner: requester aborts
      push_cmd(CMD_CONFLICT, 1, 15, 1);    // older requester marks owner aborted
      push_cmd(CMD_WRITE, 15, 0, 0);
      push_cmd(CMD_CONFLICT, 15, 1, 0);
      push_cmd(CMD_ROLLBACK, 15, 0, 0);
      push_cmd(CMD_START, 15, 0, 1);       // restart keeps the backoff
      push_cmd(CMD_ROLLBACK, 15, 0, 0);
      push_cmd(CMD_CONFLICT, 1, 1, 0);     // stamped thread aborts itself
      push_cmd(CMD_CONFLICT, 3, 0, 1);
      push_cmd(CMD_START, 0, 15, 1);

      run_phase(16'd1, 16'd1, 5'd0, 1'b1, 1'b1);
      run_phase(16'd3, 16'd64, 5'd10, 1'b0, 1'b0);
      // zero threshold never promotes, zero backoff stays zero
      run_phase(16'd0, 16'd0, 5'd16, 1'b1, 1'b0);

      // top threshold never reached, widest initial bound saturates on doubling
      wait_drained();
      configure(16'hFFFF, 16'hFFFF, 5'd31);
      idle_on = 1'b0;
      push_cmd(CMD_START, 6, 0, 0);
      repeat (8) push_cmd(CMD_WRITE, 6, $urandom_range(0, 15), $urandom_range(0, 1));
      push_cmd(CMD_CONFLICT, 6, 1, 0);
      push_cmd(CMD_CONFLICT, 1, 6, 0);
      push_cmd(CMD_START, 5, 0, 0);
      repeat (33) push_cmd(CMD_ROLLBACK, 5, $urandom_range(0, 15), $urandom_range(0, 1));
      push_cmd(CMD_START, 5, 0, 1);
      push_cmd(CMD_ROLLBACK, 5, 0, 0);

      run_phase(16'd2, 16'd40000, 5'd31, 1'b1, 1'b1);
      run_phase(16'($urandom_range(1, 8)), 16'($urandom_range(1, 65535)),
                5'($urandom_range(0, 16)), 1'b1, 1'b0);
      run_phase(THRESH_RESET, INIT_BO_RESET, STEPS_RESET, 1'b1, 1'b0);

      wait_drained();
      repeat (10) @(posedge clock);
      $display("checked %0d responses for %0d requests under several register settings",
               results_checked, items_sent);
      $display("covered promotion, backoff saturation, self conflicts, stalls");
      if (errors == 0 && verdict_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
